// ----- sv/smx_pkg.sv -----
// Shared types and constants for the three-track PCM mixer.
// No dependencies; every other file of the block imports this package.
package smx_pkg;

  localparam int unsigned BLOCK_LEN = 256;
  localparam int unsigned FRAME_W   = (BLOCK_LEN > 1) ? $clog2(BLOCK_LEN) : 1;

  localparam int unsigned SMP_W      = 8;
  localparam int unsigned VOL_W      = 8;
  localparam int unsigned FACTOR_W   = 16;
  localparam int unsigned GAIN_W     = 7;
  localparam int unsigned OUT_W      = 16;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned SVOL_W     = VOL_W + FRAC_W;
  localparam int unsigned NUM_CH     = 3;
  localparam int unsigned CH_W       = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [FACTOR_W-1:0] FACTOR_RESET = 16'd5243;
  localparam logic [GAIN_W-1:0]   GAIN_RESET   = 7'd85;

  // Centred product, sum of three products, gain-scaled magnitude, quotient
  localparam int unsigned PROD_W = 18;
  localparam int unsigned SUM_W  = 20;
  localparam int unsigned ABS_W  = 17;
  localparam int unsigned MAG_W  = ABS_W + GAIN_W;
  localparam int unsigned QUOT_W = 17;

  // floor(m / 100) == (m * DIV_RECIP) >> DIV_SHIFT for every m below 2**24
  localparam int unsigned        DIV_SHIFT = 31;
  localparam int unsigned        RECIP_W   = 25;
  localparam logic [RECIP_W-1:0] DIV_RECIP = 25'd21474837;

  localparam logic [QUOT_W-1:0] POS_LIMIT = 17'd32767;
  localparam logic [QUOT_W-1:0] NEG_LIMIT = 17'd32768;
  localparam logic [OUT_W-1:0]  OUT_MAX   = 16'h7FFF;
  localparam logic [OUT_W-1:0]  OUT_MIN   = 16'h8000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GLIDE_COEF = 2'd0,
    CFG_MIX_GAIN   = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic             first;
    logic [SMP_W-1:0] sample_a;
    logic [SMP_W-1:0] sample_b;
    logic [SMP_W-1:0] sample_c;
    logic [VOL_W-1:0] target_vol_a;
    logic [VOL_W-1:0] target_vol_b;
    logic [VOL_W-1:0] target_vol_c;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_push_t;

endpackage

// ----- sv/smx_if.sv -----
// Channel interfaces of the mixer: input frames, mixed results, register writes.
// Depends on smx_pkg for widths.
interface smx_in_if;
  import smx_pkg::*;
  logic             valid;
  logic             ready;
  logic [SMP_W-1:0] sample_a;
  logic [SMP_W-1:0] sample_b;
  logic [SMP_W-1:0] sample_c;
  logic [VOL_W-1:0] target_vol_a;
  logic [VOL_W-1:0] target_vol_b;
  logic [VOL_W-1:0] target_vol_c;
  modport source (output valid, sample_a, sample_b, sample_c,
                  target_vol_a, target_vol_b, target_vol_c, input ready);
  modport sink   (input valid, sample_a, sample_b, sample_c,
                  target_vol_a, target_vol_b, target_vol_c, output ready);
endinterface

interface smx_out_if;
  import smx_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] mixed_sample;
  modport source (output valid, mixed_sample, input ready);
  modport sink   (input valid, mixed_sample, output ready);
endinterface

interface smx_cfg_if;
  import smx_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- sv/smoothed_three_track_pcm_mixer.sv -----
// Top level of the three-track PCM mixer with smoothed volumes.
// Depends on smx_pkg, smx_if, smx_front, smx_queue and smx_back.
//
//   port    dir   handshake      payload
//   in_i    sink  valid/ready    sample_a/b/c, target_vol_a/b/c
//   out_o   src   valid/ready    mixed_sample (signed 16 bit)
//   cfg_i   sink  valid/ready    index (0 glide_coef, 1 mix_gain), data
//
// Steps: the back end takes each frame through product, gain, divide and
// saturate, and on the first frame of each block first smooths, where one shared
// 24x16 multiplier walks the three volumes, one per cycle.
// Reset clears the smoothed volumes, the block position and the queue, and
// loads the register defaults. The two-entry queue keeps taking frames, until
// it is full, while the back end works or waits on a stalled output register.
module smoothed_three_track_pcm_mixer (
  input  logic       clk_i,
  input  logic       rst_ni,
  smx_in_if.sink     in_i,
  smx_cfg_if.sink    cfg_i,
  smx_out_if.source  out_o
);
  import smx_pkg::*;

  logic [FACTOR_W-1:0] glide_coef_q;
  logic [GAIN_W-1:0]   mix_gain_q;

  q_push_t push;
  item_t   q_item;
  logic    q_ready, q_valid, q_pop;

  // registers take any write; unknown indexes drop
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      glide_coef_q <= FACTOR_RESET;
      mix_gain_q   <= GAIN_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_GLIDE_COEF: glide_coef_q <= cfg_i.data[FACTOR_W-1:0];
        CFG_MIX_GAIN:   mix_gain_q   <= cfg_i.data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // accept and tag block starts
  smx_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .q_ready_i (q_ready),
    .push_o    (push)
  );

  // decouple accept from processing
  smx_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .item_o  (q_item),
    .pop_i   (q_pop)
  );

  // smooth, mix, divide and saturate
  smx_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_item_i     (q_item),
    .q_pop_o      (q_pop),
    .glide_coef_i (glide_coef_q),
    .mix_gain_i   (mix_gain_q),
    .out_o        (out_o)
  );

endmodule

// ----- sv/smx_front.sv -----
// Front end: accepts frames, tracks the position inside the block and tags
// the first frame of each block. Depends on smx_pkg and smx_in_if.
module smx_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  smx_in_if.sink             in_i,
  input  logic               q_ready_i,
  output smx_pkg::q_push_t   push_o
);
  import smx_pkg::*;

  logic [FRAME_W-1:0] frame_q, frame_d;
  logic               accept;

  assign in_i.ready = q_ready_i;
  assign accept     = in_i.valid && q_ready_i;

  assign push_o.valid             = accept;
  assign push_o.item.first        = (frame_q == '0);
  assign push_o.item.sample_a     = in_i.sample_a;
  assign push_o.item.sample_b     = in_i.sample_b;
  assign push_o.item.sample_c     = in_i.sample_c;
  assign push_o.item.target_vol_a = in_i.target_vol_a;
  assign push_o.item.target_vol_b = in_i.target_vol_b;
  assign push_o.item.target_vol_c = in_i.target_vol_c;

  // wrap at the end of the block
  always_comb begin
    frame_d = frame_q;
    if (accept) begin
      if (frame_q == FRAME_W'(BLOCK_LEN - 1)) begin
        frame_d = '0;
      end else begin
        frame_d = frame_q + FRAME_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q <= '0;
    end else begin
      frame_q <= frame_d;
    end
  end

endmodule

// ----- sv/smx_queue.sv -----
// Two-entry item queue between front and back end.
// Depends on smx_pkg.
module smx_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  smx_pkg::q_push_t push_i,
  output logic             ready_o,
  output logic             valid_o,
  output smx_pkg::item_t   item_o,
  input  logic             pop_i
);
  import smx_pkg::*;

  item_t      mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push, do_pop;

  assign ready_o = (count_q != 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i.valid && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ----- sv/smx_back.sv -----
// Back end: smooths the volumes on block starts, scales and sums the tracks,
// applies gain, divides by 100 and saturates into the output register.
// Depends on smx_pkg and smx_out_if.
module smx_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  input  smx_pkg::item_t                q_item_i,
  output logic                          q_pop_o,
  input  logic [smx_pkg::FACTOR_W-1:0]  glide_coef_i,
  input  logic [smx_pkg::GAIN_W-1:0]    mix_gain_i,
  smx_out_if.source                     out_o
);
  import smx_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SMOOTH = 6'b000010,
    ST_PROD   = 6'b000100,
    ST_GAIN   = 6'b001000,
    ST_DIV    = 6'b010000,
    ST_DONE   = 6'b100000
  } state_e;

  state_e state_q, state_d;
  item_t  item_q;
  logic [CH_W-1:0]   ch_q, ch_d;
  logic [SVOL_W-1:0] vol_q [NUM_CH];

  logic signed [PROD_W-1:0] prod_q [NUM_CH];
  logic                     neg_q;
  logic [MAG_W-1:0]         mag_q;
  logic [QUOT_W-1:0]        quot_q;
  logic                     out_valid_q;
  logic [OUT_W-1:0]         out_data_q;

  logic out_free, load, write_out;

  // smoothing datapath, one channel per cycle on a shared multiplier
  logic [VOL_W-1:0]           tgt;
  logic [SVOL_W-1:0]          cur, goal, diff, step, new_vol;
  logic                       up;
  logic [SVOL_W+FACTOR_W-1:0] sprod, srnd;

  // mix datapath
  logic signed [SUM_W-1:0]        sum;
  logic [SUM_W-1:0]               abs_sum;
  logic [MAG_W+RECIP_W-1:0]       full;
  logic [OUT_W-1:0]               sat;
  logic signed [SMP_W:0]          centred [NUM_CH];
  logic [SMP_W-1:0]               smp [NUM_CH];
  logic [VOL_W-1:0]               whole [NUM_CH];

  assign out_free  = !out_valid_q || out_o.ready;
  assign write_out = (state_q == ST_DONE) && out_free;
  assign load      = q_valid_i && ((state_q == ST_IDLE) || write_out);
  assign q_pop_o   = load;

  assign out_o.valid        = out_valid_q;
  assign out_o.mixed_sample = out_data_q;

  always_comb begin
    case (ch_q)
      2'd0:    tgt = item_q.target_vol_a;
      2'd1:    tgt = item_q.target_vol_b;
      default: tgt = item_q.target_vol_c;
    endcase
    cur     = vol_q[ch_q];
    goal    = {tgt, {FRAC_W{1'b0}}};
    up      = (goal >= cur);
    diff    = up ? (goal - cur) : (cur - goal);
    sprod   = (SVOL_W + FACTOR_W)'(diff) * (SVOL_W + FACTOR_W)'(glide_coef_i);
    // round the decrement up so the step floors toward minus infinity
    srnd    = up ? sprod : (sprod + (SVOL_W + FACTOR_W)'({FRAC_W{1'b1}}));
    step    = srnd[SVOL_W+FACTOR_W-1:FRAC_W];
    new_vol = up ? (cur + step) : (cur - step);
  end

  always_comb begin
    smp[0] = item_q.sample_a;
    smp[1] = item_q.sample_b;
    smp[2] = item_q.sample_c;
    for (int i = 0; i < NUM_CH; i++) begin
      whole[i]   = vol_q[i][SVOL_W-1:FRAC_W];
      centred[i] = $signed({1'b0, smp[i]}) - $signed((SMP_W + 1)'(128));
    end
    sum = SUM_W'(prod_q[0]) + SUM_W'(prod_q[1]) + SUM_W'(prod_q[2]);
    abs_sum = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
    full = (MAG_W + RECIP_W)'(mag_q) * (MAG_W + RECIP_W)'(DIV_RECIP);
    if (neg_q) begin
      sat = (quot_q > NEG_LIMIT) ? OUT_MIN : OUT_W'(-quot_q);
    end else begin
      sat = (quot_q > POS_LIMIT) ? OUT_MAX : quot_q[OUT_W-1:0];
    end
  end

  always_comb begin
    state_d = state_q;
    ch_d    = ch_q;
    case (state_q)
      ST_IDLE: begin
        if (load) begin
          state_d = q_item_i.first ? ST_SMOOTH : ST_PROD;
          ch_d    = '0;
        end
      end
      ST_SMOOTH: begin
        if (ch_q == CH_W'(NUM_CH - 1)) begin
          state_d = ST_PROD;
        end else begin
          ch_d = ch_q + CH_W'(1);
        end
      end
      ST_PROD: state_d = ST_GAIN;
      ST_GAIN: state_d = ST_DIV;
      ST_DIV:  state_d = ST_DONE;
      ST_DONE: begin
        if (load) begin
          state_d = q_item_i.first ? ST_SMOOTH : ST_PROD;
          ch_d    = '0;
        end else if (write_out) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (load) item_q <= q_item_i;
    if (state_q == ST_PROD) begin
      for (int i = 0; i < NUM_CH; i++) begin
        prod_q[i] <= PROD_W'(centred[i]) * PROD_W'($signed({1'b0, whole[i]}));
      end
    end
    if (state_q == ST_GAIN) begin
      neg_q <= sum[SUM_W-1];
      mag_q <= MAG_W'(abs_sum[ABS_W-1:0]) * MAG_W'(mix_gain_i);
    end
    if (state_q == ST_DIV) quot_q <= QUOT_W'(full >> DIV_SHIFT);
    if (write_out) out_data_q <= sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ch_q        <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_CH; i++) vol_q[i] <= '0;
    end else begin
      state_q <= state_d;
      ch_q    <= ch_d;
      if (state_q == ST_SMOOTH) vol_q[ch_q] <= new_vol;
      if (write_out) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule
